### rtl/spwm_pkg.sv
// Shared constants, types and the waveform table of the three-phase sine PWM sequencer.
`timescale 1ns / 1ps

package spwm_pkg;

  // Widths fixed by the field definitions.
  localparam int WORD_W     = 12;
  localparam int SPEED_W    = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int ROM_ADDR_W = 8;
  localparam int NUM_PHASES = 3;

  // Table geometry and phase start positions.
  localparam int TABLE_DEPTH_DEF = 37;
  localparam int ROM_WORDS       = 37;
  localparam int MIN_IDX_W       = 5;
  localparam int RESET_INDEX_A   = 0;
  localparam int RESET_INDEX_B   = 24;
  localparam int RESET_INDEX_C   = 24;

  // Amplitude scaling: zero below the lower speed, scaled in between, full from the upper speed on.
  localparam int SPEED_ZERO_BELOW = 10;
  localparam int SPEED_FULL_FROM  = 50;
  localparam int SCALE_SPEED_W    = 6;
  localparam int ROUND_BIAS       = 25;
  localparam int SUM_W            = 18;

  // floor(n / 50) = floor((n >> 1) * RECIP_25 >> RECIP_SHIFT) for every n below 2^SUM_W.
  localparam int HALF_W      = SUM_W - 1;
  localparam int RECIP_W     = 22;
  localparam int RECIP_25    = 2684355;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = HALF_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED   = 1'b0,
    CFG_REVERSE = 1'b1
  } cfg_index_e;

  typedef logic [WORD_W-1:0] word_t;

  // One quarter-and-more sine period; addresses past the table read zero.
  function automatic word_t wave_word(input logic [ROM_ADDR_W-1:0] addr);
    word_t w;
    case (addr)
      8'd0:    w = 12'd2985;
      8'd1:    w = 12'd3049;
      8'd2:    w = 12'd3103;
      8'd3:    w = 12'd3144;
      8'd4:    w = 12'd3175;
      8'd5:    w = 12'd3193;
      8'd6:    w = 12'd3199;
      8'd7:    w = 12'd3193;
      8'd8:    w = 12'd3175;
      8'd9:    w = 12'd3144;
      8'd10:   w = 12'd3103;
      8'd11:   w = 12'd3049;
      8'd12:   w = 12'd2985;
      8'd13:   w = 12'd2770;
      8'd14:   w = 12'd2547;
      8'd15:   w = 12'd2317;
      8'd16:   w = 12'd2081;
      8'd17:   w = 12'd1841;
      8'd18:   w = 12'd1600;
      8'd19:   w = 12'd1358;
      8'd20:   w = 12'd1118;
      8'd21:   w = 12'd882;
      8'd22:   w = 12'd652;
      8'd23:   w = 12'd429;
      8'd24:   w = 12'd214;
      8'd25:   w = 12'd150;
      8'd26:   w = 12'd96;
      8'd27:   w = 12'd55;
      8'd28:   w = 12'd24;
      8'd29:   w = 12'd6;
      8'd30:   w = 12'd0;
      8'd31:   w = 12'd6;
      8'd32:   w = 12'd24;
      8'd33:   w = 12'd55;
      8'd34:   w = 12'd96;
      8'd35:   w = 12'd150;
      8'd36:   w = 12'd214;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### rtl/spwm_index.sv
// Bouncing table index for one phase: steps up to the last entry, then back down to zero.
`timescale 1ns / 1ps

module spwm_index #(
  parameter int TABLE_DEPTH = spwm_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = 6,
  parameter int RESET_INDEX = 0,
  parameter bit RESET_DOWN  = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  output logic [IDX_W-1:0] index_o
);

  localparam logic [IDX_W:0]   TopIdx  = (IDX_W+1)'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] TurnIdx = IDX_W'(TABLE_DEPTH - 2);

  logic [IDX_W-1:0] index_q, index_d;
  logic             down_q, down_d;
  logic [IDX_W:0]   inc;

  always_comb begin
    inc     = {1'b0, index_q} + (IDX_W+1)'(1);
    index_d = index_q;
    down_d  = down_q;
    if (step_i) begin
      if (!down_q) begin
        if (inc > TopIdx) begin
          index_d = TurnIdx;
          down_d  = 1'b1;
        end else begin
          index_d = inc[IDX_W-1:0];
        end
      end else begin
        if (index_q == '0) begin
          index_d = IDX_W'(1);
          down_d  = 1'b0;
        end else begin
          index_d = index_q - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= IDX_W'(RESET_INDEX);
      down_q  <= RESET_DOWN;
    end else begin
      index_q <= index_d;
      down_q  <= down_d;
    end
  end

  assign index_o = index_q;

endmodule

### rtl/spwm_scale.sv
// Final amplitude selection for one phase: zero, rounded word*speed/50, or the raw word.
`timescale 1ns / 1ps

module spwm_scale (
  input  logic [spwm_pkg::WORD_W-1:0]  word_i,
  input  logic [spwm_pkg::SUM_W-1:0]   sum_i,
  input  logic [spwm_pkg::SPEED_W-1:0] speed_i,
  output logic [spwm_pkg::WORD_W-1:0]  result_o
);

  localparam logic [spwm_pkg::RECIP_W-1:0] Recip =
    spwm_pkg::RECIP_W'(spwm_pkg::RECIP_25);

  logic [spwm_pkg::HALF_W-1:0] half;
  logic [spwm_pkg::PROD_W-1:0] prod;
  logic [spwm_pkg::WORD_W-1:0] quot;

  // The sum already carries the rounding bias, so a floor division by 50 rounds half up.
  always_comb begin
    half = sum_i[spwm_pkg::SUM_W-1:1];
    prod = spwm_pkg::PROD_W'(half) * spwm_pkg::PROD_W'(Recip);
    quot = prod[spwm_pkg::RECIP_SHIFT +: spwm_pkg::WORD_W];
    if (speed_i < spwm_pkg::SPEED_W'(spwm_pkg::SPEED_ZERO_BELOW)) begin
      result_o = '0;
    end else if (speed_i < spwm_pkg::SPEED_W'(spwm_pkg::SPEED_FULL_FROM)) begin
      result_o = quot;
    end else begin
      result_o = word_i;
    end
  end

endmodule

### rtl/three_phase_sine_pwm_sequencer_unit.sv
// Top level of the three-phase sine PWM sequencer: index stepping, lookup and scaling pipeline.
`timescale 1ns / 1ps

// Each accepted tick transaction with tick_i high yields one result transaction holding three
// PWM compare values, taken from a sine table at the three phase indices as they stood before
// the tick; the indices then bounce one step each between zero and TABLE_DEPTH-1. A tick
// transaction with tick_i low is absorbed and changes nothing. The block takes one transaction
// per clock cycle while in_ready_o is high. Each result passes two register stages: the first
// stage holds the table word and the product word*speed+25 for each phase, the second holds the
// final compare values (the division by 50 is a reciprocal multiply in that stage). Both
// stages advance whenever the output register is empty or being drained; while a finished
// result waits, one more tick can still enter the empty first stage before the input stalls.
// Speed below 10 forces all outputs to zero, speed 10 to 49
// scales each word by speed/50 rounded half up, and 50 or more passes words unchanged.
// Reverse swaps the values driven on the v and w outputs. Configuration writes take effect
// immediately and are meant to be made only while no tick is in flight.

module three_phase_sine_pwm_sequencer_unit #(
  parameter int TABLE_DEPTH = spwm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Tick channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              tick_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [spwm_pkg::WORD_W-1:0]       compare_phase_u_o,
  output logic [spwm_pkg::WORD_W-1:0]       compare_phase_v_o,
  output logic [spwm_pkg::WORD_W-1:0]       compare_phase_w_o,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // The index must hold the last table position and the reset positions as well.
  localparam int IdxW = ($clog2(TABLE_DEPTH) > spwm_pkg::MIN_IDX_W) ?
                        $clog2(TABLE_DEPTH) : spwm_pkg::MIN_IDX_W;
  localparam int NPh  = spwm_pkg::NUM_PHASES;

  // Configuration registers.
  logic [spwm_pkg::SPEED_W-1:0] speed_q;
  logic                         reverse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= '0;
      reverse_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spwm_pkg::CFG_SPEED:   speed_q   <= cfg_data_i[spwm_pkg::SPEED_W-1:0];
        spwm_pkg::CFG_REVERSE: reverse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. A stage loads when it is empty or its contents move on.
  logic s1_valid_q, out_valid_q;
  logic out_ready_int, s1_ready;
  logic accept, step;

  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s1_ready      = !s1_valid_q || out_ready_int;
  assign in_ready_o    = s1_ready;
  assign accept        = in_valid_i && s1_ready;
  assign step          = accept && tick_i;

  // Phase indices, advanced after each real tick.
  logic [IdxW-1:0] index_a, index_b, index_c;

  spwm_index #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW),
    .RESET_INDEX (spwm_pkg::RESET_INDEX_A),
    .RESET_DOWN  (1'b0)
  ) u_index_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .index_o (index_a)
  );

  spwm_index #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW),
    .RESET_INDEX (spwm_pkg::RESET_INDEX_B),
    .RESET_DOWN  (1'b0)
  ) u_index_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .index_o (index_b)
  );

  spwm_index #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW),
    .RESET_INDEX (spwm_pkg::RESET_INDEX_C),
    .RESET_DOWN  (1'b1)
  ) u_index_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .index_o (index_c)
  );

  // Route the indices to output phases; reverse exchanges the v and w sources.
  logic [IdxW-1:0] phase_idx [NPh];

  always_comb begin
    phase_idx[0] = index_a;
    phase_idx[1] = reverse_q ? index_c : index_b;
    phase_idx[2] = reverse_q ? index_b : index_c;
  end

  // Stage one: table lookup and the biased product for the scaled case.
  logic [spwm_pkg::WORD_W-1:0] s1_word_q [NPh];
  logic [spwm_pkg::WORD_W-1:0] s1_word_d [NPh];
  logic [spwm_pkg::SUM_W-1:0]  s1_sum_q  [NPh];
  logic [spwm_pkg::SUM_W-1:0]  s1_sum_d  [NPh];
  logic [spwm_pkg::WORD_W-1:0] scaled    [NPh];
  logic [spwm_pkg::WORD_W-1:0] out_q     [NPh];

  for (genvar p = 0; p < NPh; p++) begin : g_phase
    always_comb begin
      s1_word_d[p] = spwm_pkg::wave_word(spwm_pkg::ROM_ADDR_W'(phase_idx[p]));
      s1_sum_d[p]  = spwm_pkg::SUM_W'(s1_word_d[p]) *
                     spwm_pkg::SUM_W'(speed_q[spwm_pkg::SCALE_SPEED_W-1:0]) +
                     spwm_pkg::SUM_W'(spwm_pkg::ROUND_BIAS);
    end

    always_ff @(posedge clk_i) begin
      if (step) begin
        s1_word_q[p] <= s1_word_d[p];
        s1_sum_q[p]  <= s1_sum_d[p];
      end
    end

    // Stage two: divide by 50 and pick the amplitude range.
    spwm_scale u_scale (
      .word_i   (s1_word_q[p]),
      .sum_i    (s1_sum_q[p]),
      .speed_i  (speed_q),
      .result_o (scaled[p])
    );

    always_ff @(posedge clk_i) begin
      if (s1_valid_q && out_ready_int) begin
        out_q[p] <= scaled[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= step;
      end
      if (out_ready_int) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign compare_phase_u_o = out_q[0];
  assign compare_phase_v_o = out_q[1];
  assign compare_phase_w_o = out_q[2];

endmodule
